// ===== rtl/core/bfls_pkg.sv =====
// Shared types, constants and bit-scan functions for the bitmap bit search block.
// No dependencies; used by bfls_apb_regs, bitmap_first_last_bit_search_top, bfls_search_checker and testbench.
`default_nettype none

package bfls_pkg;

	localparam int WORD_W     = 64;
	localparam int COUNT_W    = 10;
	localparam int OFFSET_W   = 7;
	localparam int POSITION_W = 17;
	localparam int OUT_DATA_W = 24;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register indexes on the configuration port
	typedef enum logic {
		REG_SEARCH_MODE = 1'b0,
		REG_WIDTH_SEL   = 1'b1
	} reg_index_t;

	// Search modes: bit 0 picks last over first, bit 1 picks clear over set
	typedef enum logic [1:0] {
		MODE_FIRST_SET   = 2'd0,
		MODE_LAST_SET    = 2'd1,
		MODE_FIRST_CLEAR = 2'd2,
		MODE_LAST_CLEAR  = 2'd3
	} search_mode_t;

	// Word width selects; the unused code behaves as 64 bits
	typedef enum logic [1:0] {
		WIDTH_16 = 2'd0,
		WIDTH_32 = 2'd1,
		WIDTH_64 = 2'd2,
		WIDTH_64_ALT = 2'd3
	} width_sel_t;

	localparam logic [1:0] MODE_RESET  = MODE_FIRST_SET;
	localparam logic [1:0] WIDTH_RESET = WIDTH_64;

	typedef struct packed {
		logic [1:0] search_mode;
		logic [1:0] word_width_select;
	} cfg_t;

	// 1-based index of the lowest set bit, 0 if none
	function automatic logic [OFFSET_W-1:0] low_set(input logic [WORD_W-1:0] w);
		logic [OFFSET_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = OFFSET_W'(i + 1);
			end
		end
		return r;
	endfunction

	// 1-based index of the highest set bit, 0 if none
	function automatic logic [OFFSET_W-1:0] high_set(input logic [WORD_W-1:0] w);
		logic [OFFSET_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				r = OFFSET_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfls_apb_regs.sv =====
// APB register file for the bitmap bit search block: search mode and word width.
// Depends on bfls_pkg.
`default_nettype none

module bfls_apb_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [bfls_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [bfls_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [bfls_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	output bfls_pkg::cfg_t                          cfg
);
	import bfls_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] width_q;
	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign idx    = reg_index_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes, word addressed; low address bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			width_q <= WIDTH_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_SEARCH_MODE: mode_q  <= pwdata[1:0];
				REG_WIDTH_SEL:   width_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SEARCH_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, mode_q};
			REG_WIDTH_SEL:   prdata = {{(APB_DATA_W-2){1'b0}}, width_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.search_mode       = mode_q;
	assign cfg.word_width_select = width_q;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_first_last_bit_search_top.sv =====
// Top level of the bitmap first/last set/clear bit search block.
// Depends on bfls_pkg and bfls_apb_regs.
`default_nettype none

// Bitmap words stream in on the slave side, lowest index first, tlast on the
// final word. One word is taken every cycle while the input side is not held:
// each word is held in an input register, then one priority encode and one
// position update run into the running search state. The final word passes
// from the input register into the result register, which drives the master
// side; the next bitmap may start right behind it. Only a stalled result with
// another final word waiting holds the input side.
// Configuration is written through the APB port; the user must write it only
// while the stream is idle, as the block does not enforce this.
module bitmap_first_last_bit_search_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// APB configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [bfls_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [bfls_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [bfls_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	// Word stream in
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [bfls_pkg::WORD_W-1:0]        s_tdata,  // [63:0] bitmap_word
	input  wire logic                               s_tlast,  // final_word
	// Result out
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [bfls_pkg::OUT_DATA_W-1:0]    m_tdata,  // [16:0] bit_position, zero pad
	output logic                                    m_tuser   // [0] hit
);
	import bfls_pkg::*;

	cfg_t cfg;

	bfls_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register
	logic                  valid_s1;
	logic [WORD_W-1:0]     word_s1;
	logic                  last_s1;

	// Search state
	logic [COUNT_W-1:0]    count_q;
	logic                  found_q;
	logic [POSITION_W-1:0] pos_q;

	// Result register
	logic                  valid_s2;
	logic [POSITION_W-1:0] pos_s2;
	logic                  hit_s2;

	logic                  consume;
	logic                  accept;
	logic [WORD_W-1:0]     mask;
	logic [WORD_W-1:0]     word_m;
	logic [OFFSET_W-1:0]   off;
	logic [POSITION_W-1:0] base;
	logic [POSITION_W-1:0] pos_new;
	logic                  take;

	// A final word needs room in the result register; others never wait
	assign consume  = valid_s1 & (~last_s1 | ~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | consume;
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Width mask and the word index scaled to bits
	always_comb begin
		case (width_sel_t'(cfg.word_width_select))
			WIDTH_16: begin
				mask = {{(WORD_W-16){1'b0}}, {16{1'b1}}};
				base = {3'b0, count_q, 4'b0};
			end
			WIDTH_32: begin
				mask = {{(WORD_W-32){1'b0}}, {32{1'b1}}};
				base = {2'b0, count_q, 5'b0};
			end
			default: begin
				mask = '1;
				base = {1'b0, count_q, 6'b0};
			end
		endcase
	end

	// Invert for clear modes, then encode from the chosen end
	always_comb begin
		word_m  = cfg.search_mode[1] ? (~word_s1 & mask) : (word_s1 & mask);
		off     = cfg.search_mode[0] ? high_set(word_m) : low_set(word_m);
		take    = (off != '0) & (cfg.search_mode[0] | ~found_q);
		pos_new = base + {{(POSITION_W-OFFSET_W){1'b0}}, off};
	end

	// Running search state, cleared after each final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (consume) begin
			if (last_s1) begin
				count_q <= '0;
				found_q <= 1'b0;
				pos_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				if (take) begin
					found_q <= 1'b1;
					pos_q   <= pos_new;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume & last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume & last_s1) begin
			hit_s2 <= take | found_q;
			pos_s2 <= take ? pos_new : (found_q ? pos_q : '0);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W-POSITION_W){1'b0}}, pos_s2};
	assign m_tuser  = hit_s2;

	// No hit means position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("result without hit carries a nonzero position");

	// A hit has a 1-based position
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata != '0)
		else $error("hit reported at position zero");

	// Latched position only while something was found
	a_state_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> pos_q == '0)
		else $error("stale position with no hit latched");

	// Final word restarts the word count
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> count_q == '0 && !found_q)
		else $error("search state not cleared after final word");

	// Input side stalls only behind a held final word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== dv/bfls_search_checker.sv =====
// Scoreboard for the bitmap bit search block: snoops the APB port and both streams,
// keeps its own search state and compares every result beat with the predicted one.
// Depends on bfls_pkg for widths and register and mode codes.
`default_nettype none

module bfls_search_checker
	import bfls_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// APB snoop
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic                  pready,
	// Word stream snoop
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [WORD_W-1:0]     s_tdata,  // [63:0] bitmap_word
	input  wire logic                  s_tlast,  // final_word
	// Result stream snoop
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,  // [16:0] bit_position, [23:17] zero pad
	input  wire logic                  m_tuser,  // [0] hit
	output int                         outstanding,
	output int                         mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [POSITION_W-1:0] position;
		logic                  hit;
	} search_result_t;

	// Results still owed by the block, oldest first
	search_result_t awaited_results[$];

	// Shadow of the registers and of the running search
	search_mode_t          mode_q;
	width_sel_t            width_q;
	logic [COUNT_W-1:0]    word_idx;
	logic                  found;
	logic [POSITION_W-1:0] found_pos;

	function automatic int word_bits(input width_sel_t sel);
		case (sel)
			WIDTH_16: return 16;
			WIDTH_32: return 32;
			default:  return 64;
		endcase
	endfunction

	function automatic int lowest_one(input logic [WORD_W-1:0] w);
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) return i + 1;
		end
		return 0;
	endfunction

	function automatic int highest_one(input logic [WORD_W-1:0] w);
		for (int i = WORD_W; i > 0; i--) begin
			if (w[i-1]) return i;
		end
		return 0;
	endfunction

	task automatic report(input string what);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Fold one accepted word into the search; a final word yields a result
	task automatic fold_word(input logic [WORD_W-1:0] word, input logic last);
		int                span;
		int                off;
		logic              wants_last;
		logic [WORD_W-1:0] keep;
		logic [WORD_W-1:0] w;
		search_result_t    res;
		span = word_bits(width_q);
		keep = (span == WORD_W) ? '1 : ((64'd1 << span) - 64'd1);
		w = word & keep;
		if (mode_q inside {MODE_FIRST_CLEAR, MODE_LAST_CLEAR}) begin
			w = ~w & keep;
		end
		wants_last = mode_q inside {MODE_LAST_SET, MODE_LAST_CLEAR};
		off = wants_last ? highest_one(w) : lowest_one(w);
		if (off != 0 && (wants_last || !found)) begin
			found = 1'b1;
			found_pos = POSITION_W'(int'(word_idx) * span + off);
		end
		if (last) begin
			res.position = found ? found_pos : '0;
			res.hit = found;
			awaited_results.push_back(res);
			word_idx = '0;
			found = 1'b0;
			found_pos = '0;
		end else begin
			// counter is exactly as wide as the word limit, so it wraps there
			word_idx = word_idx + 1'b1;
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		search_result_t want;
		if (!arst_n) begin
			mode_q = search_mode_t'(MODE_RESET);
			width_q = width_sel_t'(WIDTH_RESET);
			word_idx = '0;
			found = 1'b0;
			found_pos = '0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// result beat against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report($sformatf("unexpected result beat: position %0d hit %0b",
						m_tdata[POSITION_W-1:0], m_tuser));
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata[POSITION_W-1:0] !== want.position) begin
						report($sformatf("bit_position %0d, predicted %0d",
							m_tdata[POSITION_W-1:0], want.position));
					end
					if (m_tdata[OUT_DATA_W-1:POSITION_W] !== '0) begin
						report($sformatf("tdata pad bits not zero: %h", m_tdata));
					end
					if (m_tuser !== want.hit) begin
						report($sformatf("hit %0b, predicted %0b", m_tuser, want.hit));
					end
				end
			end
			// word beat
			if (s_tvalid && s_tready) begin
				fold_word(s_tdata, s_tlast);
			end
			// register write
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[2]))
					REG_SEARCH_MODE: mode_q = search_mode_t'(pwdata[1:0]);
					REG_WIDTH_SEL:   width_q = width_sel_t'(pwdata[1:0]);
					default: ;
				endcase
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the bitmap bit search testbench: clock, reset, APB writes, word stimulus,
// result back-pressure, idle watchdog and verdict.
// Depends on bfls_pkg, bitmap_first_last_bit_search_top and bfls_search_checker.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bfls_pkg::*;

	localparam int RANDOM_WORDS = 300;
	localparam int LONG_WORDS   = 2**COUNT_W + 6;  // runs past the word counter wrap
	localparam int IDLE_LIMIT   = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;   // [63:0] bitmap_word
	logic                  s_tlast;   // final_word
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [16:0] bit_position, [23:17] zero pad
	logic                  m_tuser;   // [0] hit

	int   outstanding;
	int   mismatches;
	int   idle_cycles;
	logic quiet;

	bitmap_first_last_bit_search_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bfls_search_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Bitmap length: mostly one or a few words
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 1;
		if (r < 80) return $urandom_range(2, 6);
		if (r < 95) return $urandom_range(7, 20);
		return $urandom_range(21, 48);
	endfunction

	// Word content with a bias toward empty, full, lone-bit and lone-hole words
	function automatic logic [WORD_W-1:0] make_word();
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 15);
			3:       return 64'd1 << $urandom_range(0, 63);
			4:       return ~(64'd1 << $urandom_range(0, 15));
			5:       return ~(64'd1 << $urandom_range(0, 63));
			6:       return a & b & {$urandom, $urandom};
			7:       return a | b | {$urandom, $urandom};
			default: return a;
		endcase
	endfunction

	// One word beat; valid stays up across back-to-back beats
	task automatic push_word(input logic [WORD_W-1:0] word, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random_bitmap(input int len);
		for (int i = 0; i < len; i++) begin
			push_word(make_word(), i == len - 1);
		end
	endtask

	// Stop the stream, let all results out and the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic set_reg(input reg_index_t idx, input logic [1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {30'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input search_mode_t mode, input width_sel_t wsel);
		drain();
		set_reg(REG_SEARCH_MODE, mode);
		set_reg(REG_WIDTH_SEL, wsel);
	endtask

	// Result side back-pressure
	initial begin
		int run;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				run = pick_gap();
				if (run > 0) begin
					m_tready <= 1'b0;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat or register access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus and verdict
	initial begin
		int               random_words;
		int               len;
		search_mode_t     long_mode;
		logic [WORD_W-1:0] fill;
		idle_cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: first set, 64-bit words
		push_word('0, 1'b1);
		push_word(64'h8000_0000_0000_0000, 1'b1);
		push_word('0, 1'b0);
		push_word('0, 1'b0);
		push_word(64'h20, 1'b1);

		// Bits above the 16-bit width must be ignored
		configure(MODE_LAST_SET, WIDTH_16);
		push_word(64'hFFFF_FFFF_FFFF_0000, 1'b1);
		push_word(64'h1, 1'b0);
		push_word(64'h8000, 1'b1);

		configure(MODE_FIRST_CLEAR, WIDTH_32);
		push_word(64'hFFFF_FFFF, 1'b0);
		push_word(64'h0000_0000_FFFF_FFFE, 1'b1);
		push_word(64'h0000_0000_FFFF_FFFF, 1'b1);

		// Unused width code acts as 64 bits
		configure(MODE_LAST_CLEAR, WIDTH_64_ALT);
		push_word('0, 1'b1);
		push_word('1, 1'b0);
		push_word('1, 1'b1);

		// Mode change partway through a bitmap
		configure(MODE_FIRST_SET, WIDTH_64);
		push_word(64'h10, 1'b0);
		drain();
		set_reg(REG_SEARCH_MODE, MODE_LAST_SET);
		push_word(64'h3, 1'b1);

		// Width change partway through; the latched first hit must survive
		configure(MODE_FIRST_SET, WIDTH_64);
		push_word(64'h100, 1'b0);
		drain();
		set_reg(REG_WIDTH_SEL, WIDTH_16);
		push_word(64'h1, 1'b1);

		// Bitmap longer than the word counter: hits only after the wrap
		long_mode = search_mode_t'($urandom_range(0, 3));
		configure(long_mode, width_sel_t'($urandom_range(0, 3)));
		fill = (long_mode inside {MODE_FIRST_CLEAR, MODE_LAST_CLEAR}) ? '1 : '0;
		for (int i = 0; i < LONG_WORDS; i++) begin
			push_word((i < LONG_WORDS - 6) ? fill : make_word(), i == LONG_WORDS - 1);
		end

		// Random phases, each under its own settings
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			configure(search_mode_t'($urandom_range(0, 3)), width_sel_t'($urandom_range(0, 3)));
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 10)) begin
				len = pick_len();
				send_random_bitmap(len);
				random_words += len;
			end
		end
		quiet = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/bfls_pkg.sv
rtl/core/bfls_apb_regs.sv
rtl/core/bitmap_first_last_bit_search_top.sv
dv/bfls_search_checker.sv
dv/testbench.sv
